>>> src/bfre_pkg.sv
// Shared types, codes and constants for the box filter with replicated edge.
package bfre_pkg;

    // Default configuration and sizing
    localparam int WINDOW_DEF     = 5;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Configuration port geometry
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] col;
        logic [7:0] row;
        logic [3:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [3:0] filtered;
        logic       coord_error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIVIDE,
        ST_RESP
    } state_t;

endpackage

>>> src/bfre_frame_store.sv
// Frame store: one write port, one read port with registered read data.
module bfre_frame_store #(
    parameter int MAX_WIDTH  = bfre_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bfre_pkg::MAX_HEIGHT_DEF,
    parameter int AW = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [3:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [3:0]    rd_data
);
    import bfre_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [3:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/box_filter_replicate_edge_core.sv
// Box filter top level: sequencer, window address walk, accumulator and reciprocal divide.
// Sequencing: a pixel write or an out-of-frame item goes from accept straight to the result
// state; a query first walks the window reads, then the drain and divide states.
// Throughput: one item at a time, the next accepted the cycle after the result is taken;
// a query reads its window pixel by pixel through the single frame store read port.
// Reset (aresetn low, synchronous): sequencer idle, frame sizes 256, store not cleared.
module box_filter_replicate_edge_core #(
    parameter int WINDOW     = bfre_pkg::WINDOW_DEF,
    parameter int MAX_WIDTH  = bfre_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bfre_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [bfre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfre_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bfre_pkg::in_item_t                  s_item,
    // Result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output bfre_pkg::out_item_t                 m_item
);
    import bfre_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AREA   = WINDOW * WINDOW;
    localparam int HALF   = WINDOW / 2;
    localparam int KW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = $clog2(15 * AREA + 1);
    localparam int NUM_W  = $clog2(31 * AREA + 1);
    localparam int PW     = 11;
    localparam int DW     = CFG_DATA_W;
    // Divide by 2*area as a multiply by a rounded-up reciprocal, exact over the numerator range
    localparam int DIV_C  = 2 * AREA;
    localparam int DIV_W  = $clog2(DIV_C);
    localparam int RCP_SH = NUM_W + DIV_W;
    localparam int RCP    = (2 ** RCP_SH + DIV_C - 1) / DIV_C;
    localparam int RCP_W  = $clog2(RCP + 1);
    localparam int PROD_W = NUM_W + RCP_W;

    // Registers
    state_t            state_reg, state_next;
    logic [DW-1:0]     cfg_w_reg, cfg_h_reg;
    logic [7:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic [KW-1:0]     dx_reg, dx_next;
    logic [KW-1:0]     dy_reg, dy_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    out_item_t         out_reg, out_next;

    // Combinational signals
    logic [DW-1:0]     w_eff, h_eff;
    logic              in_err;
    logic              accept;
    logic              rd_en;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [3:0]        mem_rdata;
    logic [PW-1:0]     pos_c, pos_r;
    logic [DW-1:0]     clamp_c, clamp_r;
    logic [SUM_W-1:0]  sum_total;
    logic [PROD_W-1:0] quot_prod;

    function automatic logic [DW-1:0] clamp_pos(logic [PW-1:0] p, logic [DW-1:0] lim);
        logic [DW-1:0] res;
        if (p[PW-1]) begin
            res = '0;
        end else if (p >= PW'(lim)) begin
            res = lim - DW'(1);
        end else begin
            res = p[DW-1:0];
        end
        return res;
    endfunction

    // Effective frame size: zero acts as one, large values stop at the maximum
    always_comb begin
        if (cfg_w_reg == '0) begin
            w_eff = DW'(1);
        end else if (int'(cfg_w_reg) > MAX_WIDTH) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = cfg_w_reg;
        end
        if (cfg_h_reg == '0) begin
            h_eff = DW'(1);
        end else if (int'(cfg_h_reg) > MAX_HEIGHT) begin
            h_eff = DW'(MAX_HEIGHT);
        end else begin
            h_eff = cfg_h_reg;
        end
    end

    assign accept = s_valid && s_ready;
    assign in_err = ({1'b0, s_item.col} >= w_eff) || ({1'b0, s_item.row} >= h_eff);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= DIM_RESET;
            cfg_h_reg <= DIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_w_reg <= cfg_wdata;
                CFG_FRAME_HEIGHT: cfg_h_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Window position with the border replicated
    assign pos_c   = PW'({1'b0, col_reg}) + PW'(dx_reg) - PW'(HALF);
    assign pos_r   = PW'({1'b0, row_reg}) + PW'(dy_reg) - PW'(HALF);
    assign clamp_c = clamp_pos(pos_c, w_eff);
    assign clamp_r = clamp_pos(pos_r, h_eff);

    assign mem_raddr = AW'(clamp_r) * AW'(MAX_WIDTH) + AW'(clamp_c);
    assign mem_waddr = AW'(s_item.row) * AW'(MAX_WIDTH) + AW'(s_item.col);
    assign mem_we    = accept && !in_err && (s_item.operation == OP_WRITE);

    // Accumulator input and reciprocal product
    assign sum_total = sum_reg + (rd_valid_reg ? SUM_W'(mem_rdata) : SUM_W'(0));
    assign quot_prod = PROD_W'(num_reg) * PROD_W'(RCP);

    bfre_frame_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (s_item.pixel),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        col_reg <= col_next;
        row_reg <= row_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sum_reg <= sum_next;
        num_reg <= num_next;
        out_reg <= out_next;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sum_next   = sum_reg;
        num_next   = num_reg;
        out_next   = out_reg;
        rd_en      = 1'b0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    col_next = s_item.col;
                    row_next = s_item.row;
                    dx_next  = '0;
                    dy_next  = '0;
                    sum_next = '0;
                    out_next.filtered    = 4'd0;
                    out_next.coord_error = in_err;
                    if (!in_err && s_item.operation == OP_QUERY) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_READ: begin
                // one window pixel read per cycle, previous read accumulated
                rd_en    = 1'b1;
                sum_next = sum_total;
                if (dx_reg == KW'(WINDOW - 1)) begin
                    dx_next = '0;
                    if (dy_reg == KW'(WINDOW - 1)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        dy_next = dy_reg + KW'(1);
                    end
                end else begin
                    dx_next = dx_reg + KW'(1);
                end
            end
            ST_DRAIN: begin
                // last pixel lands; form 2*sum + area for the rounding divide
                num_next   = (NUM_W'(sum_total) << 1) + NUM_W'(AREA);
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                // quotient by 2*area from the reciprocal product
                out_next.filtered    = 4'(quot_prod >> RCP_SH);
                out_next.coord_error = 1'b0;
                state_next           = ST_RESP;
            end
            ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_valid_next = rd_en;
    assign m_item        = out_reg;

`ifndef SYNTH
    // Never ready for a new item while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // An out-of-frame item is answered in the next cycle
    a_err_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_err) |=> (m_valid && m_item.coord_error))
        else $error("coordinate error not reported promptly");

    // Error results carry a zero level
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.coord_error) |-> (m_item.filtered == 4'd0))
        else $error("error result with nonzero level");

    // Read data is only taken for reads issued during the window walk
    a_rd_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("stray frame store read data");
`endif

endmodule

>>> tb/sv/filter_scoreboard_pkg.sv
// Scoreboard for the box filter: frame mirror, window-mean prediction and result checks.
package filter_scoreboard_pkg;
    import bfre_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int HALF         = WIN / 2;
    localparam int AREA         = WIN * WIN;
    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int MAX_H        = MAX_HEIGHT_DEF;
    localparam int REPORT_LIMIT = 10;

    class filter_scoreboard;
        // mirror of the frame store, addressed row*MAX_W+col
        logic [3:0]  level_mirror [MAX_W*MAX_H];
        bit          level_written [MAX_W*MAX_H];
        int unsigned cols_in_use;
        int unsigned rows_in_use;
        out_item_t   expected_q [$];
        int unsigned fail_count;

        function new();
            cols_in_use = MAX_W;
            rows_in_use = MAX_H;
            fail_count  = 0;
        endfunction

        // sizes out of range act as the nearest legal size
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
            int unsigned dim;
            dim = wdata;
            if (idx == CFG_FRAME_WIDTH) begin
                cols_in_use = (dim < 1) ? 1 : (dim > MAX_W) ? MAX_W : dim;
            end else if (idx == CFG_FRAME_HEIGHT) begin
                rows_in_use = (dim < 1) ? 1 : (dim > MAX_H) ? MAX_H : dim;
            end
        endfunction

        // replicated border: positions past an edge read the edge pixel
        function int clamp_edge(int pos, int unsigned limit);
            if (pos < 0) return 0;
            if (pos > int'(limit) - 1) return int'(limit) - 1;
            return pos;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // accepted input item: update the mirror and queue the expected result
        function void note_input(in_item_t item);
            out_item_t   exp_item;
            int unsigned sum;
            int          dy, dx, r, c;
            exp_item = '0;
            sum      = 0;
            if (item.col >= cols_in_use || item.row >= rows_in_use) begin
                exp_item.coord_error = 1'b1;
            end else if (item.operation == OP_WRITE) begin
                level_mirror[int'(item.row) * MAX_W + int'(item.col)]  = item.pixel;
                level_written[int'(item.row) * MAX_W + int'(item.col)] = 1'b1;
            end else begin
                for (dy = 0; dy < WIN; dy++) begin
                    r = clamp_edge(int'(item.row) + dy - HALF, rows_in_use);
                    for (dx = 0; dx < WIN; dx++) begin
                        c = clamp_edge(int'(item.col) + dx - HALF, cols_in_use);
                        sum += level_mirror[r * MAX_W + c];
                    end
                end
                // exact round half up of sum/AREA
                exp_item.filtered = 4'((2 * sum + AREA) / (2 * AREA));
            end
            expected_q.push_back(exp_item);
        endfunction

        function void report_fault(string msg);
            fail_count++;
            if (fail_count <= REPORT_LIMIT) $display("%s", msg);
        endfunction

        // accepted result item: compare with the oldest expectation
        function void check_result(out_item_t got);
            out_item_t exp_item;
            if (expected_q.size() == 0) begin
                report_fault($sformatf("unexpected result: filtered=%0d coord_error=%0d",
                                       got.filtered, got.coord_error));
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.filtered !== exp_item.filtered ||
                got.coord_error !== exp_item.coord_error) begin
                report_fault($sformatf(
                    "mismatch: expected filtered=%0d coord_error=%0d, got filtered=%0d coord_error=%0d",
                    exp_item.filtered, exp_item.coord_error, got.filtered, got.coord_error));
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_box_filter_replicate_edge_core.sv
// Testbench top for the box filter core: corner cases, frame size phases, random traffic.
module tb_box_filter_replicate_edge_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bfre_pkg::*;
    import filter_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;

    int unsigned tx_idle_pct = 28;
    int unsigned rx_idle_pct = 28;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned cycle_count = 0;

    filter_scoreboard sb = new();

    box_filter_replicate_edge_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: check accepted items, random back-pressure, long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic in_item_t make_item(logic op, logic [7:0] col, logic [7:0] row,
                                           logic [3:0] level);
        in_item_t item;
        item.operation = op;
        item.col       = col;
        item.row       = row;
        item.pixel     = level;
        return item;
    endfunction

    // mostly in-frame queries and writes, the rest past the frame edge
    function automatic in_item_t random_item();
        in_item_t    item;
        int unsigned pick;
        bit          col_out;
        pick = $urandom_range(99);
        item = make_item(OP_QUERY, 8'($urandom_range(sb.cols_in_use - 1)),
                         8'($urandom_range(sb.rows_in_use - 1)), 4'($urandom_range(15)));
        if (pick >= 45 && pick < 72) begin
            item.operation = OP_WRITE;
        end else if (pick >= 72) begin
            item.operation = 1'($urandom_range(1));
            col_out = (sb.rows_in_use == MAX_H) || (sb.cols_in_use < MAX_W && $urandom_range(1));
            if (sb.cols_in_use < MAX_W && col_out) begin
                item.col = 8'($urandom_range(MAX_W - 1, sb.cols_in_use));
            end
            if (sb.rows_in_use < MAX_H && (!col_out || $urandom_range(3) == 0)) begin
                item.row = 8'($urandom_range(MAX_H - 1, sb.rows_in_use));
            end
        end
        return item;
    endfunction

    // offer one item, with random gaps before it; returns at the accepting edge
    task automatic send_item(in_item_t item);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(item);
    endtask

    // resize the frame once the block has gone idle
    task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(CFG_FRAME_WIDTH, w);
        sb.set_reg(CFG_FRAME_HEIGHT, h);
    endtask

    // write every pixel of the frame in use that has never been written
    task automatic fill_frame();
        int r, c;
        for (r = 0; r < int'(sb.rows_in_use); r++) begin
            for (c = 0; c < int'(sb.cols_in_use); c++) begin
                if (!sb.level_written[r * MAX_W + c]) begin
                    send_item(make_item(OP_WRITE, 8'(c), 8'(r), 4'($urandom_range(15))));
                end
            end
        end
    endtask

    task automatic run_random(int count);
        repeat (count) send_item(random_item());
    endtask

    initial begin : stimulus
        int r, c;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full-size frame: top-left corner all at full level
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) send_item(make_item(OP_WRITE, 8'(c), 8'(r), 4'hF));
        end
        send_item(make_item(OP_QUERY, 8'd0, 8'd0, 4'h0));
        // bottom-right corner: one bright pixel replicated nine times by the border
        for (r = 253; r < 256; r++) begin
            for (c = 253; c < 256; c++) begin
                send_item(make_item(OP_WRITE, 8'(c), 8'(r),
                                    (r == 255 && c == 255) ? 4'hF : 4'h0));
            end
        end
        send_item(make_item(OP_QUERY, 8'd255, 8'd255, 4'hF));

        // zero sizes act as a single pixel
        set_frame(9'd0, 9'd0);
        run_random(80);

        // one full-width row; receiver holds off so the block backs up
        set_frame(9'd256, 9'd1);
        hold_req = 1'b1;
        fill_frame();
        run_random(100);

        // one full-height column
        set_frame(9'd1, 9'd256);
        fill_frame();
        run_random(100);

        // oversized registers act as the maximum
        set_frame(9'd511, 9'd1);
        run_random(60);
        set_frame(9'd1, 9'd511);
        run_random(60);

        // back-to-back traffic, no gaps on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_frame(9'd8, 9'd8);
        fill_frame();
        run_random(200);
        tx_idle_pct = 28;
        rx_idle_pct = 28;

        set_frame(9'd13, 9'd6);
        fill_frame();
        run_random(200);

        repeat (2) begin
            set_frame(9'($urandom_range(20, 2)), 9'($urandom_range(20, 2)));
            fill_frame();
            run_random(120);
        end

        // drain outstanding results, then allow for stray ones
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> box_filter_replicate_edge_core.f
src/bfre_pkg.sv
src/bfre_frame_store.sv
src/box_filter_replicate_edge_core.sv
tb/sv/filter_scoreboard_pkg.sv
tb/sv/tb_box_filter_replicate_edge_core.sv
